[rtl/blr_pkg.sv]
`timescale 1ns / 1ps
// blr_pkg: shared types and constants for the line rasteriser
// no dependencies; imported by every rtl module of the block
package blr_pkg;

  // canvas and field widths
  localparam int CANVAS_SIZE = 64;
  localparam int COORD_W     = 6;
  localparam int INK_W       = 8;
  localparam int ERR_W       = COORD_W + 2;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);

  // depth of the request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one classified line request
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic               dir_x_neg;
    logic               dir_y_neg;
    logic [INK_W-1:0]   ink;
    logic               dotted;
  } line_desc_t;

  // queue status seen by both neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // saturate a coordinate to the canvas
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = (v > COORD_MAX) ? COORD_MAX : v;
    return r;
  endfunction

endpackage

[rtl/blr_front.sv]
`timescale 1ns / 1ps
// blr_front: takes a line request, clamps it, finds directions and spans
// depends on blr_pkg; feeds blr_queue
module blr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [blr_pkg::COORD_W-1:0] in_start_x,
  input  logic [blr_pkg::COORD_W-1:0] in_start_y,
  input  logic [blr_pkg::COORD_W-1:0] in_end_x,
  input  logic [blr_pkg::COORD_W-1:0] in_end_y,
  input  logic [blr_pkg::INK_W-1:0]   in_ink,
  input  logic                        in_dotted,
  input  blr_pkg::q_stat_t            q_stat,
  output logic                        q_push,
  output blr_pkg::line_desc_t         q_wdata
);
  import blr_pkg::*;

  logic       valid_r, valid_nxt;
  line_desc_t desc_r, desc_nxt;
  logic       accept;
  logic [COORD_W-1:0] sx, sy, gx, gy;

  // classify the incoming word
  always_comb begin
    sx = clamp_coord(in_start_x);
    sy = clamp_coord(in_start_y);
    gx = clamp_coord(in_end_x);
    gy = clamp_coord(in_end_y);
    desc_nxt.start_x   = sx;
    desc_nxt.start_y   = sy;
    desc_nxt.goal_x    = gx;
    desc_nxt.goal_y    = gy;
    desc_nxt.dir_x_neg = !(sx < gx);
    desc_nxt.dir_y_neg = !(sy < gy);
    desc_nxt.span_x    = (sx < gx) ? (gx - sx) : (sx - gx);
    desc_nxt.span_y    = (sy < gy) ? (gy - sy) : (sy - gy);
    desc_nxt.ink       = in_ink;
    desc_nxt.dotted    = in_dotted;
  end

  // holding stage in front of the queue
  assign q_push  = valid_r && !q_stat.full;
  assign in_full = valid_r && q_stat.full;
  assign accept  = in_push && !in_full;
  assign q_wdata = desc_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

[rtl/blr_queue.sv]
`timescale 1ns / 1ps
// blr_queue: short fifo of classified line requests
// depends on blr_pkg; sits between blr_front and blr_back
module blr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  blr_pkg::line_desc_t wdata,
  input  logic                pop,
  output blr_pkg::line_desc_t rdata,
  output blr_pkg::q_stat_t    stat
);
  import blr_pkg::*;

  line_desc_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  // pointer wrap at the queue depth
  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    r = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/blr_back.sv]
`timescale 1ns / 1ps
// blr_back: bresenham walker with a registered output word
// depends on blr_pkg; reads requests from blr_queue
module blr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blr_pkg::q_stat_t            q_stat,
  input  blr_pkg::line_desc_t         q_rdata,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [blr_pkg::COORD_W-1:0] out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0] out_pixel_y,
  output logic [blr_pkg::INK_W-1:0]   out_pixel_ink,
  output logic                        out_write_enable,
  output logic                        out_last
);
  import blr_pkg::*;

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r, span_x_r, span_y_r;
  logic [COORD_W-1:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [COORD_W-1:0] span_x_nxt, span_y_nxt;
  logic               dxn_r, dyn_r, dxn_nxt, dyn_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic               phase_r, phase_nxt, dotted_r, dotted_nxt;
  logic [INK_W-1:0]   ink_r, ink_nxt;
  logic [COORD_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic [INK_W-1:0]   oink_r, oink_nxt;
  logic               owe_r, olast_r, owe_nxt, olast_nxt;

  logic slot_free, at_end, step_x, step_y;
  logic signed [ERR_W:0] e2, sx_s, sy_s, err_step;

  assign slot_free = !ov_r || out_pop;
  assign at_end    = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;

  // error term decision
  always_comb begin
    e2       = {err_r, 1'b0};
    sx_s     = $signed({{(ERR_W + 1 - COORD_W){1'b0}}, span_x_r});
    sy_s     = $signed({{(ERR_W + 1 - COORD_W){1'b0}}, span_y_r});
    step_x   = e2 > -sy_s;
    step_y   = e2 < sx_s;
    err_step = {err_r[ERR_W-1], err_r} - (step_x ? sy_s : '0) + (step_y ? sx_s : '0);
  end

  // walker and output register next values
  always_comb begin
    state_nxt  = state_r;
    ov_nxt     = ov_r && !out_pop;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    span_x_nxt = span_x_r;
    span_y_nxt = span_y_r;
    dxn_nxt    = dxn_r;
    dyn_nxt    = dyn_r;
    err_nxt    = err_r;
    phase_nxt  = phase_r;
    dotted_nxt = dotted_r;
    ink_nxt    = ink_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oink_nxt   = oink_r;
    owe_nxt    = owe_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        // load the next request
        if (!q_stat.empty) begin
          state_nxt  = ST_WALK;
          cur_x_nxt  = q_rdata.start_x;
          cur_y_nxt  = q_rdata.start_y;
          goal_x_nxt = q_rdata.goal_x;
          goal_y_nxt = q_rdata.goal_y;
          span_x_nxt = q_rdata.span_x;
          span_y_nxt = q_rdata.span_y;
          dxn_nxt    = q_rdata.dir_x_neg;
          dyn_nxt    = q_rdata.dir_y_neg;
          err_nxt    = $signed(ERR_W'({2'b00, q_rdata.span_x})
                               - ERR_W'({2'b00, q_rdata.span_y}));
          phase_nxt  = 1'b1;
          dotted_nxt = q_rdata.dotted;
          ink_nxt    = q_rdata.ink;
        end
      end
      ST_WALK: begin
        // emit one point and step, or go idle after the last point
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ox_nxt    = cur_x_r;
          oy_nxt    = cur_y_r;
          oink_nxt  = ink_r;
          owe_nxt   = dotted_r ? phase_r : 1'b1;
          olast_nxt = at_end;
          phase_nxt = phase_r ^ dotted_r;
          if (at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            err_nxt = err_step[ERR_W-1:0];
            if (step_x) cur_x_nxt = dxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
            if (step_y) cur_y_nxt = dyn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    goal_x_r <= goal_x_nxt;
    goal_y_r <= goal_y_nxt;
    span_x_r <= span_x_nxt;
    span_y_r <= span_y_nxt;
    dxn_r    <= dxn_nxt;
    dyn_r    <= dyn_nxt;
    err_r    <= err_nxt;
    phase_r  <= phase_nxt;
    dotted_r <= dotted_nxt;
    ink_r    <= ink_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oink_r   <= oink_nxt;
    owe_r    <= owe_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_empty        = !ov_r;
  assign out_pixel_x      = ox_r;
  assign out_pixel_y      = oy_r;
  assign out_pixel_ink    = oink_r;
  assign out_write_enable = owe_r;
  assign out_last         = olast_r;

endmodule

[rtl/bresenham_line_rasterizer_unit.sv]
`timescale 1ns / 1ps
// a request taken when all is idle goes through the front holding register, the queue
// and the walker's load step before its first point reaches the registered result ports
// throughput: one point per cycle while the output word is free or popped, plus a
// load from the queue between lines; up to 64 points per line on the 64-wide canvas
// reset (synchronous, rst_n low): queue and walker empty, empty high, full low
module bresenham_line_rasterizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [blr_pkg::COORD_W-1:0] in_start_x,
  input  logic [blr_pkg::COORD_W-1:0] in_start_y,
  input  logic [blr_pkg::COORD_W-1:0] in_end_x,
  input  logic [blr_pkg::COORD_W-1:0] in_end_y,
  input  logic [blr_pkg::INK_W-1:0]   in_ink,
  input  logic                        in_dotted,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [blr_pkg::COORD_W-1:0] out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0] out_pixel_y,
  output logic [blr_pkg::INK_W-1:0]   out_pixel_ink,
  output logic                        out_write_enable,
  output logic                        out_last
);
  import blr_pkg::*;

  q_stat_t    q_stat;
  logic       q_push, q_pop;
  line_desc_t q_wdata, q_rdata;

  // front: accept and classify
  blr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_ink     (in_ink),
    .in_dotted  (in_dotted),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // request queue
  blr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: line walker
  blr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_ink    (out_pixel_ink),
    .out_write_enable (out_write_enable),
    .out_last         (out_last)
  );

`ifndef SYNTH
  // queue never read while empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // queue never written while full
  a_push_nonfull: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  // reset leaves both sides open and no word waiting
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full && q_stat.empty))
    else $error("state not cleared by reset");

  // a full input side implies a full queue
  a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_stat.full)
    else $error("input stalled with room in queue");
`endif

endmodule
